// File: hdl/sipq_pkg.sv
// sipq_pkg: shared types and codes for the sorted insert process queue
// used by sipq_cell and sorted_insert_process_queue; no dependencies
`default_nettype none

package sipq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 16;
    localparam int TAG_BITS_DEF = 8;

    // action codes carried by each input item
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_REMOVE = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic ins;      // place the new entry this cycle
        logic sorted;   // insert by key, else append at back
        logic rem;      // shift everything one place toward the front
    } t_cell_ctl;

endpackage

`default_nettype wire

// File: hdl/sipq_cell.sv
// sipq_cell: one queue position holding a key and a tag
// depends on sipq_pkg for the control struct
`default_nettype none

module sipq_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = sipq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sipq_pkg::TAG_BITS_DEF,
    parameter int CNT_W    = 5
) (
    input  wire                     i_clk,
    input  sipq_pkg::t_cell_ctl     i_ctl,
    input  wire  [CNT_W-1:0]        i_count,
    input  wire  [KEY_BITS-1:0]     i_new_key,
    input  wire  [TAG_BITS-1:0]     i_new_tag,
    input  wire                     i_prev_pfx,
    input  wire  [KEY_BITS-1:0]     i_prev_key,
    input  wire  [TAG_BITS-1:0]     i_prev_tag,
    input  wire  [KEY_BITS-1:0]     i_next_key,
    input  wire  [TAG_BITS-1:0]     i_next_tag,
    output logic                    o_pfx,
    output logic [KEY_BITS-1:0]     o_key,
    output logic [TAG_BITS-1:0]     o_tag
);

    logic [KEY_BITS-1:0] r_key, n_key;
    logic [TAG_BITS-1:0] r_tag, n_tag;
    logic                occ;
    logic                cand;

    // positions below the count are occupied
    assign occ  = (CNT_W'(IDX) < i_count);
    // candidate insertion point: first empty place or first larger key
    assign cand = !occ || (i_ctl.sorted && (r_key > i_new_key));
    assign o_pfx = i_prev_pfx || cand;

    always_comb begin
        n_key = r_key;
        n_tag = r_tag;
        if (i_ctl.rem) begin
            n_key = i_next_key;
            n_tag = i_next_tag;
        end else if (i_ctl.ins) begin
            if (i_prev_pfx) begin
                n_key = i_prev_key;
                n_tag = i_prev_tag;
            end else if (cand) begin
                n_key = i_new_key;
                n_tag = i_new_tag;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_tag <= n_tag;
    end

    assign o_key = r_key;
    assign o_tag = r_tag;

endmodule

`default_nettype wire

// File: hdl/sorted_insert_process_queue.sv
// sorted_insert_process_queue: top level, a shift-register queue of sipq_cell
// depends on sipq_pkg and sipq_cell
//
// usage
//   input channel: i_in_valid / o_in_ready carry one item (action, arrival key,
//   process tag). action append puts the entry at the back, insert puts it
//   before the first entry with a key greater than its own, or at the back if
//   none is, remove takes the front entry, the fourth code only reports status.
//   output channel: o_out_valid / i_out_ready carry one result per item with
//   the removed entry (if any), the empty flag, the drop flag and the count.
//   result: registered; it shows in the cycle after the item is accepted.
//   throughput: one item per cycle while results are taken; every cell compares
//   its key against the broadcast key in parallel and a prefix flag ripples down
//   the cell row to mark the insertion point.
//   stall: the result sits in an output register; while it is not taken
//   o_in_ready is low, and it rises again in the cycle the result leaves.
//   reset: synchronous active low, empties the queue and the output register.
//   entry storage is not cleared; only places below the count are ever read.
`default_nettype none

module sorted_insert_process_queue #(
    parameter int CAPACITY = sipq_pkg::CAPACITY_DEF,
    parameter int KEY_BITS = sipq_pkg::KEY_BITS_DEF,
    parameter int TAG_BITS = sipq_pkg::TAG_BITS_DEF,
    localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    // input items
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire  [1:0]          i_action,
    input  wire  [KEY_BITS-1:0] i_arrival_key,
    input  wire  [TAG_BITS-1:0] i_process_tag,
    // result items
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output logic                o_dequeued_valid,
    output logic [KEY_BITS-1:0] o_dequeued_arrival,
    output logic [TAG_BITS-1:0] o_dequeued_tag,
    output logic                o_queue_empty,
    output logic                o_insert_dropped,
    output logic [CNT_W-1:0]    o_entry_count
);

    // occupancy and output register
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_out_valid;
    logic                r_dv;
    logic [KEY_BITS-1:0] r_da;
    logic [TAG_BITS-1:0] r_dt;
    logic                r_empty;
    logic                r_drop;
    logic [CNT_W-1:0]    r_cnt_out;

    logic                accept;
    logic                full;
    logic                is_add;
    logic                do_ins;
    logic                do_rem;
    logic                drop;
    sipq_pkg::t_action   act;
    sipq_pkg::t_cell_ctl ctl;

    // cell row wiring
    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    logic [TAG_BITS-1:0] cell_tag [CAPACITY];
    logic                cell_pfx [CAPACITY];

    // a new item enters when the output register is free or being emptied
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;
    assign act        = sipq_pkg::t_action'(i_action);
    assign full       = (r_count == CNT_W'(CAPACITY));
    assign is_add     = (act == sipq_pkg::ACT_APPEND) || (act == sipq_pkg::ACT_INSERT);
    assign do_ins     = accept && is_add && !full;
    assign drop       = accept && is_add && full;
    assign do_rem     = accept && (act == sipq_pkg::ACT_REMOVE) && (r_count != '0);

    assign ctl.ins    = do_ins;
    assign ctl.sorted = (act == sipq_pkg::ACT_INSERT);
    assign ctl.rem    = do_rem;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // row of cells, front at index 0; each cell hands its entry to a neighbor
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                prev_pfx;
        logic [KEY_BITS-1:0] prev_key, next_key;
        logic [TAG_BITS-1:0] prev_tag, next_tag;

        if (g == 0) begin : g_front
            assign prev_pfx = 1'b0;
            assign prev_key = i_arrival_key;
            assign prev_tag = i_process_tag;
        end else begin : g_mid
            assign prev_pfx = cell_pfx[g-1];
            assign prev_key = cell_key[g-1];
            assign prev_tag = cell_tag[g-1];
        end

        // the back cell refills from itself; it is empty after a remove anyway
        if (g == CAPACITY - 1) begin : g_back
            assign next_key = cell_key[g];
            assign next_tag = cell_tag[g];
        end else begin : g_inner
            assign next_key = cell_key[g+1];
            assign next_tag = cell_tag[g+1];
        end

        sipq_cell #(
            .IDX      (g),
            .KEY_BITS (KEY_BITS),
            .TAG_BITS (TAG_BITS),
            .CNT_W    (CNT_W)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (ctl),
            .i_count    (r_count),
            .i_new_key  (i_arrival_key),
            .i_new_tag  (i_process_tag),
            .i_prev_pfx (prev_pfx),
            .i_prev_key (prev_key),
            .i_prev_tag (prev_tag),
            .i_next_key (next_key),
            .i_next_tag (next_tag),
            .o_pfx      (cell_pfx[g]),
            .o_key      (cell_key[g]),
            .o_tag      (cell_tag[g])
        );
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, front entry captured before the row shifts
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_dv      <= do_rem;
            r_da      <= do_rem ? cell_key[0] : '0;
            r_dt      <= do_rem ? cell_tag[0] : '0;
            r_empty   <= (n_count == '0);
            r_drop    <= drop;
            r_cnt_out <= n_count;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_dequeued_valid   = r_dv;
    assign o_dequeued_arrival = r_da;
    assign o_dequeued_tag     = r_dt;
    assign o_queue_empty      = r_empty;
    assign o_insert_dropped   = r_drop;
    assign o_entry_count      = r_cnt_out;

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_rem_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_rem |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("remove did not lower the count");

    a_ins_inc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_ins |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("insert did not raise the count");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_queue_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with count");

    a_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_insert_dropped) |-> !o_dequeued_valid)
        else $error("drop and dequeue in one result");

endmodule

`default_nettype wire

// File: test/sorted_insert_process_queue_test.sv
// sorted_insert_process_queue_test: self-checking bench for the sorted insert process queue
// drives items through the valid/ready input channel, mirrors the queue in a shadow copy
// and checks every result item; depends on sipq_pkg and sorted_insert_process_queue

module sorted_insert_process_queue_test;

    localparam int CAP       = sipq_pkg::CAPACITY_DEF;
    localparam int KEY_W     = sipq_pkg::KEY_BITS_DEF;
    localparam int TAG_W     = sipq_pkg::TAG_BITS_DEF;
    localparam int CNT_W     = $clog2(CAP + 1);
    localparam int N_RANDOM  = 800;
    localparam int IDLE_MAX  = 1000;   // cycles with no handshake before giving up

    // phases of the random part
    localparam int PH_FILL  = 0;
    localparam int PH_DRAIN = 1;
    localparam int PH_MIXED = 2;

    typedef struct packed {
        logic             deq_valid;
        logic [KEY_W-1:0] deq_key;
        logic [TAG_W-1:0] deq_tag;
        logic             empty;
        logic             dropped;
        logic [CNT_W-1:0] count;
    } t_status;

    typedef struct packed {
        sipq_pkg::t_action act;
        logic [KEY_W-1:0]  key;
        logic [TAG_W-1:0]  tag;
        logic              typed;    // expected status written into the row
        t_status           status;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [1:0]       i_action = '0;
    logic [KEY_W-1:0] i_arrival_key = '0;
    logic [TAG_W-1:0] i_process_tag = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_dequeued_valid;
    logic [KEY_W-1:0] o_dequeued_arrival;
    logic [TAG_W-1:0] o_dequeued_tag;
    logic             o_queue_empty;
    logic             o_insert_dropped;
    logic [CNT_W-1:0] o_entry_count;

    // shadow copy of the queue, front at index 0
    logic [KEY_W-1:0] shadow_keys [CAP];
    logic [TAG_W-1:0] shadow_tags [CAP];
    int               shadow_count = 0;

    t_status awaited_status [$];
    t_row    directed_rows [$];
    int      n_errors = 0;
    bit      calm = 1'b0;          // no gaps on either side while set
    int      ready_hold = 0;
    int      idle_cycles = 0;

    sorted_insert_process_queue u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_action           (i_action),
        .i_arrival_key      (i_arrival_key),
        .i_process_tag      (i_process_tag),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_dequeued_valid   (o_dequeued_valid),
        .o_dequeued_arrival (o_dequeued_arrival),
        .o_dequeued_tag     (o_dequeued_tag),
        .o_queue_empty      (o_queue_empty),
        .o_insert_dropped   (o_insert_dropped),
        .o_entry_count      (o_entry_count)
    );

    always #4 i_clk = ~i_clk;

    // applies one action to the shadow queue and returns the status it leaves
    function automatic t_status apply_to_shadow_queue(sipq_pkg::t_action act,
                                                      logic [KEY_W-1:0] key,
                                                      logic [TAG_W-1:0] tag);
        t_status st;
        int      pos;
        bit      found;
        st = '0;
        if (act == sipq_pkg::ACT_APPEND || act == sipq_pkg::ACT_INSERT) begin
            if (shadow_count >= CAP) begin
                st.dropped = 1'b1;
            end else begin
                pos = shadow_count;
                found = 1'b0;
                // stable: land before the first entry whose key is greater
                if (act == sipq_pkg::ACT_INSERT) begin
                    for (int i = 0; i < shadow_count; i++) begin
                        if (!found && shadow_keys[i] > key) begin
                            pos = i;
                            found = 1'b1;
                        end
                    end
                end
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_keys[i] = shadow_keys[i-1];
                    shadow_tags[i] = shadow_tags[i-1];
                end
                shadow_keys[pos] = key;
                shadow_tags[pos] = tag;
                shadow_count++;
            end
        end else if (act == sipq_pkg::ACT_REMOVE && shadow_count > 0) begin
            st.deq_valid = 1'b1;
            st.deq_key   = shadow_keys[0];
            st.deq_tag   = shadow_tags[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_keys[i-1] = shadow_keys[i];
                shadow_tags[i-1] = shadow_tags[i];
            end
            shadow_count--;
        end
        st.empty = (shadow_count == 0);
        st.count = CNT_W'(shadow_count);
        return st;
    endfunction

    function automatic t_status status_of(logic dv, logic [KEY_W-1:0] dk, logic [TAG_W-1:0] dt,
                                          logic emp, logic drp, int cnt);
        t_status st;
        st.deq_valid = dv;
        st.deq_key   = dk;
        st.deq_tag   = dt;
        st.empty     = emp;
        st.dropped   = drp;
        st.count     = CNT_W'(cnt);
        return st;
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // keys: full range, a narrow band for ties, or the extremes
    function automatic logic [KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return KEY_W'($urandom_range(0, 65535));
        if (r < 85) return KEY_W'($urandom_range(0, 7));
        return (r < 92) ? '0 : '1;
    endfunction

    function automatic sipq_pkg::t_action pick_action(int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (r < 40) return sipq_pkg::ACT_INSERT;
                if (r < 75) return sipq_pkg::ACT_APPEND;
                if (r < 95) return sipq_pkg::ACT_REMOVE;
            end
            PH_DRAIN: begin
                if (r < 70) return sipq_pkg::ACT_REMOVE;
                if (r < 80) return sipq_pkg::ACT_INSERT;
                if (r < 90) return sipq_pkg::ACT_APPEND;
            end
            default: begin
                if (r < 35) return sipq_pkg::ACT_INSERT;
                if (r < 55) return sipq_pkg::ACT_APPEND;
                if (r < 95) return sipq_pkg::ACT_REMOVE;
            end
        endcase
        return sipq_pkg::ACT_NOP;
    endfunction

    task automatic add_row(sipq_pkg::t_action act, logic [KEY_W-1:0] key,
                           logic [TAG_W-1:0] tag, logic typed, t_status st);
        t_row row;
        row.act    = act;
        row.key    = key;
        row.tag    = tag;
        row.typed  = typed;
        row.status = st;
        directed_rows.push_back(row);
    endtask

    // presents one item after a random gap and waits for its handshake
    task automatic send_item(sipq_pkg::t_action act, logic [KEY_W-1:0] key,
                             logic [TAG_W-1:0] tag, logic typed, t_status typed_status);
        int      gap;
        t_status predicted;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action      = act;
        i_arrival_key = key;
        i_process_tag = tag;
        i_in_valid    = 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = apply_to_shadow_queue(act, key, tag);
        awaited_status.push_back(typed ? typed_status : predicted);
    endtask

    task automatic report_field(string name, int want, int got);
        n_errors++;
        $error("%s: expected %0d, got %0d", name, want, got);
    endtask

    // receiver side: random stalls on the result channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (ready_hold > 0) begin
                i_out_ready = 1'b0;
                ready_hold--;
            end else begin
                i_out_ready = 1'b1;
                if ($urandom_range(0, 2) == 0) ready_hold = pick_gap();
            end
        end
    end

    // result checking against the oldest awaited status
    always @(posedge i_clk) begin
        t_status want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_status.size() == 0) begin
                n_errors++;
                $error("result item with no item outstanding");
            end else begin
                want = awaited_status.pop_front();
                if (o_dequeued_valid !== want.deq_valid)
                    report_field("dequeued_valid", want.deq_valid, o_dequeued_valid);
                if (o_dequeued_arrival !== want.deq_key)
                    report_field("dequeued_arrival", want.deq_key, o_dequeued_arrival);
                if (o_dequeued_tag !== want.deq_tag)
                    report_field("dequeued_tag", want.deq_tag, o_dequeued_tag);
                if (o_queue_empty !== want.empty)
                    report_field("queue_empty", want.empty, o_queue_empty);
                if (o_insert_dropped !== want.dropped)
                    report_field("insert_dropped", want.dropped, o_insert_dropped);
                if (o_entry_count !== want.count)
                    report_field("entry_count", want.count, o_entry_count);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int                phase;
        int                phase_left;
        sipq_pkg::t_action act;

        // empty queue, then the two extreme keys, then an append out of order
        add_row(sipq_pkg::ACT_REMOVE, '0, '0, 1'b1,
                status_of(1'b0, '0, '0, 1'b1, 1'b0, 0));
        add_row(sipq_pkg::ACT_NOP, '1, '1, 1'b1,
                status_of(1'b0, '0, '0, 1'b1, 1'b0, 0));
        add_row(sipq_pkg::ACT_INSERT, '1, '1, 1'b1,
                status_of(1'b0, '0, '0, 1'b0, 1'b0, 1));
        add_row(sipq_pkg::ACT_INSERT, '0, '0, 1'b1,
                status_of(1'b0, '0, '0, 1'b0, 1'b0, 2));
        add_row(sipq_pkg::ACT_APPEND, 16'h8000, 8'h5A, 1'b0, '0);
        // equal inserted keys keep arrival order
        add_row(sipq_pkg::ACT_INSERT, 16'h8000, 8'hA5, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'h8000, 8'h3C, 1'b0, '0);
        add_row(sipq_pkg::ACT_REMOVE, 16'h1234, 8'h77, 1'b1,
                status_of(1'b1, '0, '0, 1'b0, 1'b0, 4));
        // fill to capacity with a spread of keys
        add_row(sipq_pkg::ACT_INSERT, 16'h0001, 8'h01, 1'b0, '0);
        add_row(sipq_pkg::ACT_APPEND, 16'h0002, 8'h02, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'hFFFE, 8'h80, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'h7FFF, 8'h7F, 1'b0, '0);
        add_row(sipq_pkg::ACT_APPEND, 16'h5555, 8'h55, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'hAAAA, 8'hAA, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'h0000, 8'hFE, 1'b0, '0);
        add_row(sipq_pkg::ACT_APPEND, 16'hFFFF, 8'h00, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'h8000, 8'h11, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'h0100, 8'h22, 1'b0, '0);
        add_row(sipq_pkg::ACT_APPEND, 16'h00FF, 8'h33, 1'b0, '0);
        add_row(sipq_pkg::ACT_INSERT, 16'hFFFF, 8'h44, 1'b0, '0);
        // full: both placing actions are refused, status still reported
        add_row(sipq_pkg::ACT_INSERT, 16'h0000, 8'h99, 1'b1,
                status_of(1'b0, '0, '0, 1'b0, 1'b1, CAP));
        add_row(sipq_pkg::ACT_APPEND, 16'h4242, 8'h42, 1'b1,
                status_of(1'b0, '0, '0, 1'b0, 1'b1, CAP));
        add_row(sipq_pkg::ACT_NOP, 16'h0000, 8'h00, 1'b1,
                status_of(1'b0, '0, '0, 1'b0, 1'b0, CAP));
        add_row(sipq_pkg::ACT_REMOVE, 16'h0000, 8'h00, 1'b0, '0);

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].act, directed_rows[i].key, directed_rows[i].tag,
                      directed_rows[i].typed, directed_rows[i].status);

        // random part: fill and drain phases push the queue to full and empty
        phase = PH_MIXED;
        phase_left = 0;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (phase_left == 0) begin
                phase = $urandom_range(PH_FILL, PH_MIXED);
                phase_left = $urandom_range(15, 45);
                calm = ($urandom_range(0, 3) == 0);
            end
            phase_left--;
            act = pick_action(phase);
            send_item(act, pick_key(), TAG_W'($urandom_range(0, 255)), 1'b0, '0);
        end
        calm = 1'b0;
        @(negedge i_clk);
        i_in_valid = 1'b0;

        while (awaited_status.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
